FILE: src/tws_pkg.sv
// Shared types and constants for the two-window maximum sum unit.
package tws_pkg;

    localparam int LEN_W = 6;
    localparam int CFG_DATA_W = 32;
    localparam int PADDR_W = 3;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic
    {
        REG_FIRST_LEN  = 1'b0,
        REG_SECOND_LEN = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic last;
        logic reached;
    } item_flags_t;

endpackage

FILE: src/tws_front.sv
// Front end: accepts samples, keeps the sample history and classifies each beat.
module tws_front
    import tws_pkg::*;
#(
    parameter int MAX_WIN = 32,
    parameter int SAMPLE_BITS = 16,
    parameter int LW = 6
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   clear,
    input  logic [LW-1:0]          first_len,
    input  logic [LW-1:0]          second_len,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   last,
    input  logic                   queue_full,
    output logic                   push,
    output logic [SAMPLE_BITS-1:0] tap_first,
    output logic [SAMPLE_BITS-1:0] tap_second,
    output logic [SAMPLE_BITS-1:0] tap_span,
    output item_flags_t            flags
);

    localparam int HIST = 2 * MAX_WIN;
    localparam int P1W = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1;
    localparam int P2W = $clog2(HIST);
    localparam int CW = $clog2(HIST + 1);

    logic [SAMPLE_BITS-1:0] near_mem [MAX_WIN];
    logic [SAMPLE_BITS-1:0] far_mem [HIST];

    logic [P1W-1:0]         ptr1_reg;
    logic [P1W-1:0]         ptr1_next;
    logic [P2W-1:0]         ptr2_reg;
    logic [P2W-1:0]         ptr2_next;
    logic [CW-1:0]          seen_reg;
    logic [CW-1:0]          seen_next;
    logic [CW-1:0]          count_now;
    logic [SAMPLE_BITS-1:0] rd_first_reg;
    logic [SAMPLE_BITS-1:0] rd_second_reg;
    logic [SAMPLE_BITS-1:0] rd_span_reg;
    logic                   accept;
    logic [LW:0]            span;
    logic [P1W:0]           first_raw;
    logic [P1W:0]           second_raw;
    logic [P2W:0]           span_raw;
    logic [P1W-1:0]         first_addr;
    logic [P1W-1:0]         second_addr;
    logic [P2W-1:0]         span_addr;

    assign in_ready = !queue_full;
    assign accept = in_valid && !queue_full;
    assign push = accept;

    assign span = {1'b0, first_len} + {1'b0, second_len};

    // Read addresses point at the sample the next beat will need.
    assign first_raw = {1'b0, ptr1_reg} + (P1W + 1)'(MAX_WIN + 1) - (P1W + 1)'(first_len);
    assign second_raw = {1'b0, ptr1_reg} + (P1W + 1)'(MAX_WIN + 1) - (P1W + 1)'(second_len);
    assign span_raw = {1'b0, ptr2_reg} + (P2W + 1)'(HIST + 1) - (P2W + 1)'(span);

    always_comb
    begin
        if (first_raw >= (P1W + 1)'(MAX_WIN))
        begin
            first_addr = P1W'(first_raw - (P1W + 1)'(MAX_WIN));
        end
        else
        begin
            first_addr = P1W'(first_raw);
        end
        if (second_raw >= (P1W + 1)'(MAX_WIN))
        begin
            second_addr = P1W'(second_raw - (P1W + 1)'(MAX_WIN));
        end
        else
        begin
            second_addr = P1W'(second_raw);
        end
        if (span_raw >= (P2W + 1)'(HIST))
        begin
            span_addr = P2W'(span_raw - (P2W + 1)'(HIST));
        end
        else
        begin
            span_addr = P2W'(span_raw);
        end
    end

    always_comb
    begin
        ptr1_next = (32'(ptr1_reg) == MAX_WIN - 1) ? '0 : ptr1_reg + P1W'(1);
        ptr2_next = (32'(ptr2_reg) == HIST - 1) ? '0 : ptr2_reg + P2W'(1);
        count_now = (32'(seen_reg) == HIST) ? seen_reg : seen_reg + CW'(1);
        seen_next = last ? '0 : count_now;
    end

    // Samples older than the start of the sequence read as zero.
    assign tap_first = (32'(seen_reg) >= 32'(first_len)) ? rd_first_reg : '0;
    assign tap_second = (32'(seen_reg) >= 32'(second_len)) ? rd_second_reg : '0;
    assign tap_span = (32'(seen_reg) >= 32'(span)) ? rd_span_reg : '0;
    assign flags.last = last;
    assign flags.reached = (32'(count_now) >= 32'(span));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            near_mem[ptr1_reg] <= sample;
            far_mem[ptr2_reg] <= sample;
            rd_first_reg <= (first_len == LW'(1)) ? sample : near_mem[first_addr];
            rd_second_reg <= (second_len == LW'(1)) ? sample : near_mem[second_addr];
            rd_span_reg <= far_mem[span_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr1_reg <= '0;
            ptr2_reg <= '0;
            seen_reg <= '0;
        end
        else if (clear)
        begin
            seen_reg <= '0;
        end
        else if (accept)
        begin
            ptr1_reg <= ptr1_next;
            ptr2_reg <= ptr2_next;
            seen_reg <= seen_next;
        end
    end

`ifndef SYNTHESIS
    a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(seen_reg) <= HIST)
        else $error("Sample count exceeds the history depth.");
`endif

endmodule

FILE: src/tws_queue.sv
// Short queue between the front end and the back end.
module tws_queue
    import tws_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int QPW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [QPW-1:0]   wr_ptr_reg;
    logic [QPW-1:0]   rd_ptr_reg;
    logic [QPW:0]     count_reg;
    logic [QPW:0]     count_next;

    assign full = (count_reg == (QPW + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPW + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPW + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPW'(1);
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPW + 1)'(QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");
`endif

endmodule

FILE: src/tws_back.sv
// Back end: running window sums, best earlier windows and the result register.
module tws_back
    import tws_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_W = 21
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   clear,
    input  logic                   entry_valid,
    output logic                   pop,
    input  logic [SAMPLE_BITS-1:0] entry_sample,
    input  logic [SAMPLE_BITS-1:0] entry_tap_first,
    input  logic [SAMPLE_BITS-1:0] entry_tap_second,
    input  logic [SAMPLE_BITS-1:0] entry_tap_span,
    input  item_flags_t            entry_flags,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SUM_W:0]         max_sum,
    output logic                   too_short
);

    logic [SUM_W-1:0] first_now_reg;
    logic [SUM_W-1:0] second_now_reg;
    logic [SUM_W-1:0] first_lag_reg;
    logic [SUM_W-1:0] second_lag_reg;
    logic [SUM_W-1:0] first_now_next;
    logic [SUM_W-1:0] second_now_next;
    logic [SUM_W-1:0] first_lag_next;
    logic [SUM_W-1:0] second_lag_next;

    logic             stage_valid_reg;
    item_flags_t      stage_flags_reg;
    logic [SUM_W-1:0] stage_first_now_reg;
    logic [SUM_W-1:0] stage_second_now_reg;
    logic [SUM_W-1:0] stage_first_lag_reg;
    logic [SUM_W-1:0] stage_second_lag_reg;

    logic [SUM_W-1:0] best_first_reg;
    logic [SUM_W-1:0] best_second_reg;
    logic [SUM_W:0]   best_total_reg;
    logic [SUM_W-1:0] best_first_next;
    logic [SUM_W-1:0] best_second_next;
    logic [SUM_W:0]   best_total_next;
    logic [SUM_W:0]   cand_a;
    logic [SUM_W:0]   cand_b;

    logic             out_valid_reg;
    logic [SUM_W:0]   max_sum_reg;
    logic             too_short_reg;

    logic             advance;
    logic             fire;

    assign advance = !out_valid_reg || out_ready;
    assign pop = advance && entry_valid && !clear;
    assign fire = advance && stage_valid_reg;

    assign out_valid = out_valid_reg;
    assign max_sum = max_sum_reg;
    assign too_short = too_short_reg;

    always_comb
    begin
        first_now_next = first_now_reg + SUM_W'(entry_sample) - SUM_W'(entry_tap_first);
        second_now_next = second_now_reg + SUM_W'(entry_sample) - SUM_W'(entry_tap_second);
        first_lag_next = first_lag_reg + SUM_W'(entry_tap_second) - SUM_W'(entry_tap_span);
        second_lag_next = second_lag_reg + SUM_W'(entry_tap_first) - SUM_W'(entry_tap_span);
    end

    always_comb
    begin
        best_first_next = best_first_reg;
        best_second_next = best_second_reg;
        best_total_next = best_total_reg;
        if (stage_flags_reg.reached)
        begin
            if (stage_first_lag_reg > best_first_reg)
            begin
                best_first_next = stage_first_lag_reg;
            end
            if (stage_second_lag_reg > best_second_reg)
            begin
                best_second_next = stage_second_lag_reg;
            end
        end
        cand_a = {1'b0, stage_second_now_reg} + {1'b0, best_first_next};
        cand_b = {1'b0, stage_first_now_reg} + {1'b0, best_second_next};
        if (stage_flags_reg.reached)
        begin
            if (cand_a > best_total_next)
            begin
                best_total_next = cand_a;
            end
            if (cand_b > best_total_next)
            begin
                best_total_next = cand_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_now_reg <= '0;
            second_now_reg <= '0;
            first_lag_reg <= '0;
            second_lag_reg <= '0;
            best_first_reg <= '0;
            best_second_reg <= '0;
            best_total_reg <= '0;
            stage_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                first_now_reg <= '0;
                second_now_reg <= '0;
                first_lag_reg <= '0;
                second_lag_reg <= '0;
                best_first_reg <= '0;
                best_second_reg <= '0;
                best_total_reg <= '0;
                stage_valid_reg <= 1'b0;
            end
            else if (advance)
            begin
                stage_valid_reg <= entry_valid;
                if (entry_valid)
                begin
                    if (entry_flags.last)
                    begin
                        first_now_reg <= '0;
                        second_now_reg <= '0;
                        first_lag_reg <= '0;
                        second_lag_reg <= '0;
                    end
                    else
                    begin
                        first_now_reg <= first_now_next;
                        second_now_reg <= second_now_next;
                        first_lag_reg <= first_lag_next;
                        second_lag_reg <= second_lag_next;
                    end
                end
                if (stage_valid_reg)
                begin
                    if (stage_flags_reg.last)
                    begin
                        best_first_reg <= '0;
                        best_second_reg <= '0;
                        best_total_reg <= '0;
                    end
                    else
                    begin
                        best_first_reg <= best_first_next;
                        best_second_reg <= best_second_next;
                        best_total_reg <= best_total_next;
                    end
                end
            end
            if (advance)
            begin
                out_valid_reg <= stage_valid_reg && stage_flags_reg.last && !clear;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            stage_flags_reg <= entry_flags;
            stage_first_now_reg <= first_now_next;
            stage_second_now_reg <= second_now_next;
            stage_first_lag_reg <= first_lag_next;
            stage_second_lag_reg <= second_lag_next;
        end
        if (fire && stage_flags_reg.last)
        begin
            max_sum_reg <= stage_flags_reg.reached ? best_total_next : '0;
            too_short_reg <= !stage_flags_reg.reached;
        end
    end

`ifndef SYNTHESIS
    a_short_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && too_short_reg) |-> (max_sum_reg == '0))
        else $error("A too-short result carries a nonzero sum.");

    a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && entry_flags.last) |=>
            (first_now_reg == '0 && second_now_reg == '0 &&
             first_lag_reg == '0 && second_lag_reg == '0))
        else $error("Window sums not cleared after the last beat.");

    a_best_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && stage_flags_reg.last && !clear) |=>
            (best_total_reg == '0 && best_first_reg == '0 && best_second_reg == '0))
        else $error("Best sums not cleared after the last beat.");
`endif

endmodule

FILE: src/two_window_max_sum_unit.sv
// Top level of the two-window maximum sum unit: register port, front end, queue, back end.
//
// On the beat marked last, the unit returns the largest sum of two non-overlapping windows
// of the programmed lengths (either order), or a too-short flag with a zero sum when the
// sequence held fewer samples than both lengths together. It takes one sample per cycle
// while the output is not stalled, a rate set by the per-beat update of the running window
// sums in the back end; the last sample passes through the queue and the back-end stage
// register before its result is registered. A four-beat queue lets the input run on for
// up to four beats while a result waits before the input stalls. The user must write
// window lengths through the register port only while the unit is idle; the unit does not
// enforce this, and a write restarts the sequence. History needs no clearing pass after
// reset or between sequences, because a sample count masks stale entries.
module two_window_max_sum_unit
    import tws_pkg::*;
#(
    parameter int MAX_WIN = 32,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [PADDR_W-1:0]                       paddr,
    input  logic [CFG_DATA_W-1:0]                    pwdata,
    output logic [CFG_DATA_W-1:0]                    prdata,
    output logic                                     pready,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [SAMPLE_BITS-1:0]                   sample,
    input  logic                                     last,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [SAMPLE_BITS+$clog2(MAX_WIN):0]     max_sum,
    output logic                                     too_short
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WIN);
    localparam int LW = $clog2(MAX_WIN + 1);
    localparam int FW = $bits(item_flags_t);
    localparam int QW = 4 * SAMPLE_BITS + FW;

    logic [LEN_W-1:0]       first_len_reg;
    logic [LEN_W-1:0]       second_len_reg;
    logic [LW-1:0]          first_len;
    logic [LW-1:0]          second_len;
    logic                   cfg_write;
    reg_index_t             cfg_index;

    logic                   push;
    logic                   pop;
    logic                   queue_full;
    logic                   queue_empty;
    logic [SAMPLE_BITS-1:0] tap_first;
    logic [SAMPLE_BITS-1:0] tap_second;
    logic [SAMPLE_BITS-1:0] tap_span;
    item_flags_t            front_flags;
    logic [QW-1:0]          push_data;
    logic [QW-1:0]          pop_data;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_comb
    begin
        case (cfg_index)
            REG_FIRST_LEN:  prdata = CFG_DATA_W'(first_len_reg);
            REG_SECOND_LEN: prdata = CFG_DATA_W'(second_len_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_len_reg <= LEN_W'(1);
            second_len_reg <= LEN_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FIRST_LEN:  first_len_reg <= pwdata[LEN_W-1:0];
                REG_SECOND_LEN: second_len_reg <= pwdata[LEN_W-1:0];
                default:        first_len_reg <= first_len_reg;
            endcase
        end
    end

    // A length of zero acts as one, and lengths beyond the window limit are clamped.
    always_comb
    begin
        if (first_len_reg == '0)
        begin
            first_len = LW'(1);
        end
        else if (32'(first_len_reg) > MAX_WIN)
        begin
            first_len = LW'(MAX_WIN);
        end
        else
        begin
            first_len = LW'(first_len_reg);
        end
        if (second_len_reg == '0)
        begin
            second_len = LW'(1);
        end
        else if (32'(second_len_reg) > MAX_WIN)
        begin
            second_len = LW'(MAX_WIN);
        end
        else
        begin
            second_len = LW'(second_len_reg);
        end
    end

    tws_front #(
        .MAX_WIN     (MAX_WIN),
        .SAMPLE_BITS (SAMPLE_BITS),
        .LW          (LW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (cfg_write),
        .first_len  (first_len),
        .second_len (second_len),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .last       (last),
        .queue_full (queue_full),
        .push       (push),
        .tap_first  (tap_first),
        .tap_second (tap_second),
        .tap_span   (tap_span),
        .flags      (front_flags)
    );

    assign push_data = {front_flags, sample, tap_first, tap_second, tap_span};

    tws_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    tws_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .clear            (cfg_write),
        .entry_valid      (!queue_empty),
        .pop              (pop),
        .entry_sample     (pop_data[3*SAMPLE_BITS +: SAMPLE_BITS]),
        .entry_tap_first  (pop_data[2*SAMPLE_BITS +: SAMPLE_BITS]),
        .entry_tap_second (pop_data[SAMPLE_BITS +: SAMPLE_BITS]),
        .entry_tap_span   (pop_data[0 +: SAMPLE_BITS]),
        .entry_flags      (item_flags_t'(pop_data[QW-1 -: FW])),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .max_sum          (max_sum),
        .too_short        (too_short)
    );

endmodule

FILE: dv/two_window_max_sum_unit_tb.sv
// Self-checking testbench for the two-window maximum sum unit with random sequences and stalls.
module two_window_max_sum_unit_tb;
    import tws_pkg::*;

    localparam int HIST_DEPTH = 64;
    localparam int WIN_LIMIT = 32;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 60;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int QUIET_AFTER = 1450;
    localparam int PHASE_ITEMS = 120;
    localparam int PRINT_LIMIT = 40;
    localparam logic [15:0] SAMPLE_MAX = 16'hFFFF;

    typedef struct packed
    {
        logic [21:0] total;
        logic        too_short;
    } pair_result_t;

    typedef enum int unsigned
    {
        FILL_RANDOM,
        FILL_MAX,
        FILL_SMALL,
        FILL_EXTREMES
    } fill_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [15:0]           sample = '0;
    logic                  last = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [21:0]           max_sum;
    logic                  too_short;

    logic [5:0]   first_len_reg;
    logic [5:0]   second_len_reg;
    logic [15:0]  sample_hist [HIST_DEPTH];
    logic [20:0]  first_now;
    logic [20:0]  second_now;
    logic [20:0]  first_lagged;
    logic [20:0]  second_lagged;
    logic [20:0]  first_peak;
    logic [20:0]  second_peak;
    logic [21:0]  best_pair;
    int unsigned  seen_samples;
    pair_result_t pending_pairs [$];

    int unsigned error_count = 0;
    int unsigned random_items = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    bit          hold_request = 1'b0;
    int unsigned quiet_cycles = 0;

    two_window_max_sum_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .max_sum   (max_sum),
        .too_short (too_short)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned clamp_window(logic [5:0] len);
        if (len == 0)
            return 1;
        if (len > WIN_LIMIT)
            return WIN_LIMIT;
        return len;
    endfunction

    function void clear_window_state();
        for (int i = 0; i < HIST_DEPTH; i++)
            sample_hist[i] = '0;
        first_now = '0;
        second_now = '0;
        first_lagged = '0;
        second_lagged = '0;
        first_peak = '0;
        second_peak = '0;
        best_pair = '0;
        seen_samples = 0;
    endfunction

    function void predict_window_sums(logic [15:0] x, logic is_last);
        int unsigned  lf;
        int unsigned  ls;
        logic [21:0]  candidate;
        pair_result_t res;
        lf = clamp_window(first_len_reg);
        ls = clamp_window(second_len_reg);
        first_now = first_now + x - sample_hist[lf-1];
        second_now = second_now + x - sample_hist[ls-1];
        first_lagged = first_lagged + sample_hist[ls-1] - sample_hist[ls+lf-1];
        second_lagged = second_lagged + sample_hist[lf-1] - sample_hist[lf+ls-1];
        for (int i = HIST_DEPTH - 1; i > 0; i--)
            sample_hist[i] = sample_hist[i-1];
        sample_hist[0] = x;
        if (seen_samples < HIST_DEPTH)
            seen_samples++;
        if (seen_samples >= lf + ls)
        begin
            if (first_lagged > first_peak)
                first_peak = first_lagged;
            if (second_lagged > second_peak)
                second_peak = second_lagged;
            candidate = {1'b0, second_now} + {1'b0, first_peak};
            if (candidate > best_pair)
                best_pair = candidate;
            candidate = {1'b0, first_now} + {1'b0, second_peak};
            if (candidate > best_pair)
                best_pair = candidate;
        end
        if (is_last)
        begin
            res.too_short = (seen_samples < lf + ls);
            res.total = res.too_short ? '0 : best_pair;
            pending_pairs.insert(pending_pairs.size(), res);
            clear_window_state();
        end
    endfunction

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("MISMATCH %s: got %0d, expected %0d at %0t", field, got, want, $time);
    endtask

    task automatic send_sample(logic [15:0] x, logic is_last);
        int unsigned gap;
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        sample <= x;
        last <= is_last;
        do
            @(posedge clk);
        while (!in_ready);
        predict_window_sums(x, is_last);
    endtask

    task automatic write_window_len(reg_index_t idx, logic [5:0] len);
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_pairs.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(int'(idx) * 4);
        pwdata <= {26'($urandom()), len};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_FIRST_LEN)
            first_len_reg = len;
        else
            second_len_reg = len;
        clear_window_state();
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [15:0] pick_sample(fill_t fill);
        case (fill)
            FILL_MAX:      return SAMPLE_MAX;
            FILL_SMALL:    return 16'($urandom_range(0, 15));
            FILL_EXTREMES: return $urandom_range(0, 1) ? SAMPLE_MAX : 16'd0;
            default:       return 16'($urandom());
        endcase
    endfunction

    task automatic send_sequence(int unsigned count, fill_t fill, bit terminate);
        for (int unsigned i = 0; i < count; i++)
        begin
            send_sample(pick_sample(fill), terminate && (i == count - 1));
            random_items++;
        end
    endtask

    task automatic test_power_on_lengths();
        send_sample(16'd7, 1'b1);
        send_sample(16'd0, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
    endtask

    task automatic test_exact_fit();
        write_window_len(REG_FIRST_LEN, 6'd2);
        write_window_len(REG_SECOND_LEN, 6'd3);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h0010, 1'b0);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'h0003, 1'b0);
        send_sample(16'hFFFE, 1'b1);
    endtask

    task automatic test_length_clamp();
        write_window_len(REG_FIRST_LEN, 6'd0);
        write_window_len(REG_SECOND_LEN, 6'd2);
        send_sample(16'd100, 1'b0);
        send_sample(16'd1, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
    endtask

    task automatic test_abandoned_sequence();
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        write_window_len(REG_SECOND_LEN, 6'd1);
        send_sample(16'd3, 1'b0);
        send_sample(16'd9, 1'b1);
    endtask

    task automatic test_output_backpressure();
        write_window_len(REG_FIRST_LEN, 6'd1);
        hold_request = 1'b1;
        for (int i = 0; i < 24; i++)
            send_sample(16'($urandom()), i[0]);
    endtask

    task automatic test_random_sequences();
        logic [5:0]  fixed_first [4] = '{6'd32, 6'd0, 6'd63, 6'd1};
        logic [5:0]  fixed_second [4] = '{6'd32, 6'd63, 6'd0, 6'd32};
        logic [5:0]  lf_val;
        logic [5:0]  ls_val;
        int unsigned phase;
        int unsigned need;
        int unsigned seq_len;
        int unsigned budget;
        fill_t       fill;
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (phase < 4)
            begin
                lf_val = fixed_first[phase];
                ls_val = fixed_second[phase];
            end
            else if ($urandom_range(0, 1))
            begin
                lf_val = 6'($urandom_range(1, 8));
                ls_val = 6'($urandom_range(1, 8));
            end
            else
            begin
                lf_val = 6'($urandom_range(0, 63));
                ls_val = 6'($urandom_range(0, 63));
            end
            if ($urandom_range(0, 1))
            begin
                write_window_len(REG_FIRST_LEN, lf_val);
                write_window_len(REG_SECOND_LEN, ls_val);
            end
            else
            begin
                write_window_len(REG_SECOND_LEN, ls_val);
                write_window_len(REG_FIRST_LEN, lf_val);
            end
            need = clamp_window(lf_val) + clamp_window(ls_val);
            if (random_items >= QUIET_AFTER)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
            end
            budget = random_items + PHASE_ITEMS;
            while (random_items < budget)
            begin
                case ($urandom_range(0, 9))
                    0, 1:    seq_len = $urandom_range(1, need);
                    8, 9:    seq_len = $urandom_range(need, 80);
                    default: seq_len = need + $urandom_range(0, 12);
                endcase
                fill = fill_t'($urandom_range(0, 3));
                send_sequence(seq_len, fill, 1'b1);
            end
            if ($urandom_range(0, 1))
                send_sequence($urandom_range(1, need), FILL_RANDOM, 1'b0);
            phase++;
        end
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        pair_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pairs.size() == 0)
            begin
                report_mismatch("unexpected beat, max_sum", max_sum, 0);
            end
            else
            begin
                want = pending_pairs.pop_front();
                if (max_sum !== want.total)
                    report_mismatch("max_sum", max_sum, want.total);
                if (too_short !== want.too_short)
                    report_mismatch("too_short", too_short, want.too_short);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        first_len_reg = 6'd1;
        second_len_reg = 6'd1;
        clear_window_state();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        gap_pct = 20;
        stall_pct = 20;
        test_power_on_lengths();
        test_exact_fit();
        test_length_clamp();
        test_abandoned_sequence();
        test_output_backpressure();
        test_random_sequences();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_pairs.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
